// File: rtl/core/ecrl_pkg.sv
// Shared constants, types and helpers for the exception context ring log.
package ecrl_pkg;

  localparam int ENTRIES        = 4;
  localparam int CONTEXT_WORDS  = 32;
  localparam int TAG_INDEX_BITS = 16;
  localparam int MAX_RESULTS    = 32;

  localparam logic [31:0] ID_BASE_RESET = 32'h0001_0000;

  localparam int SLOT_W   = $clog2(ENTRIES);
  localparam int OCC_W    = $clog2(ENTRIES + 1);
  localparam int CW_W     = (CONTEXT_WORDS > 1) ? $clog2(CONTEXT_WORDS) : 1;
  localparam int ADDR_W   = $clog2(ENTRIES * CONTEXT_WORDS);
  localparam int COPY_MAX = (CONTEXT_WORDS < MAX_RESULTS) ? CONTEXT_WORDS : MAX_RESULTS;
  localparam logic [2:0] PEND_FULL = (ENTRIES > 7) ? 3'd7 : 3'(ENTRIES);

  localparam logic [2:0] OP_DISCARD  = 3'd0;
  localparam logic [2:0] OP_RESERVE  = 3'd1;
  localparam logic [2:0] OP_WRITE    = 3'd2;
  localparam logic [2:0] OP_COMPLETE = 3'd3;
  localparam logic [2:0] OP_POP      = 3'd4;
  localparam logic [2:0] OP_COPY     = 3'd5;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_NODATA = 2'd2;

  typedef enum logic [2:0] {
    CMD_DISCARD,
    CMD_RESERVE,
    CMD_WRITE,
    CMD_COMPLETE,
    CMD_POP,
    CMD_COPY,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [4:0]        widx;
    logic [31:0]       wdata;
    logic [5:0]        csize;
    logic [31:0]       tref;
    logic [31:0]       cid;
    logic [5:0]        limit;
    logic              seq_ok;
    logic [SLOT_W-1:0] slot;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] tag;
    logic [31:0] task_out;
    logic [5:0]  words;
    logic        last;
    logic [2:0]  pending;
  } res_t;

  function automatic logic [2:0] pend_of(input logic [OCC_W-1:0] occ);
    logic [OCC_W+2:0] wide;
    wide = {3'b000, occ};
    return (wide > 7) ? 3'd7 : wide[2:0];
  endfunction

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(ENTRIES - 1)) ? '0 : s + 1'b1;
  endfunction

endpackage

// File: rtl/core/ecrl_front.sv
// Front end: configuration register, input decode and command classification.
module ecrl_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [31:0]         cfg_wdata,
  input  logic [2:0]          op,
  input  logic [4:0]          word_index,
  input  logic [31:0]         word_data,
  input  logic [5:0]          ctx_len,
  input  logic [31:0]         task_ref,
  input  logic [31:0]         req_tag,
  input  logic [5:0]          size_limit,
  output ecrl_pkg::cmd_t      cmd,
  output logic [31:0]         id_base
);

  logic [31:0] id_base_r;
  logic [31:0] seq;
  logic [6:0]  csize_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_base_r <= ecrl_pkg::ID_BASE_RESET;
    end else if (cfg_we) begin
      id_base_r <= cfg_wdata;
    end
  end

  assign id_base   = id_base_r;
  assign seq       = req_tag - id_base_r;
  assign csize_ext = {1'b0, ctx_len};

  always_comb begin
    cmd.widx   = word_index;
    cmd.wdata  = word_data;
    cmd.csize  = (csize_ext > 7'(ecrl_pkg::CONTEXT_WORDS)) ?
                 6'(ecrl_pkg::CONTEXT_WORDS) : ctx_len;
    cmd.tref   = task_ref;
    cmd.cid    = req_tag;
    cmd.limit  = size_limit;
    cmd.seq_ok = (seq >> ecrl_pkg::TAG_INDEX_BITS) == 32'd0;
    cmd.slot   = seq[ecrl_pkg::SLOT_W-1:0];
    unique case (op)
      ecrl_pkg::OP_DISCARD:  cmd.kind = ecrl_pkg::CMD_DISCARD;
      ecrl_pkg::OP_RESERVE:  cmd.kind = ecrl_pkg::CMD_RESERVE;
      ecrl_pkg::OP_WRITE:    cmd.kind = ecrl_pkg::CMD_WRITE;
      ecrl_pkg::OP_COMPLETE: cmd.kind = ecrl_pkg::CMD_COMPLETE;
      ecrl_pkg::OP_POP:      cmd.kind = ecrl_pkg::CMD_POP;
      ecrl_pkg::OP_COPY:     cmd.kind = ecrl_pkg::CMD_COPY;
      default:               cmd.kind = ecrl_pkg::CMD_NOP;
    endcase
  end

endmodule

// File: rtl/core/ecrl_queue.sv
// Two-entry command queue between the front end and the back end.
module ecrl_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  ecrl_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop,
  output ecrl_pkg::cmd_t pop_cmd
);

  ecrl_pkg::cmd_t slots_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_cmd    = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots_r[wr_ptr_r] <= push_cmd;
  end

endmodule

// File: rtl/core/ecrl_back.sv
// Back end: ring state, entry tables, context memory and result staging.
module ecrl_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic [31:0]    id_base,
  input  logic           q_valid,
  input  ecrl_pkg::cmd_t q_cmd,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output ecrl_pkg::res_t out_res,
  output logic [31:0]    out_word
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_LOOK = 3'b010,
    S_COPY = 3'b100
  } state_t;

  localparam int SW = ecrl_pkg::SLOT_W;
  localparam int OW = ecrl_pkg::OCC_W;
  localparam int AW = ecrl_pkg::ADDR_W;
  localparam int CW = ecrl_pkg::CONTEXT_WORDS;

  state_t                        state_r, state_nxt;
  ecrl_pkg::cmd_t                cur_r, cur_nxt;
  logic [ecrl_pkg::TAG_INDEX_BITS-1:0] wr_seq_r, wr_seq_nxt;
  logic [SW-1:0]                 wr_slot_r, wr_slot_nxt;
  logic [SW-1:0]                 rd_slot_r, rd_slot_nxt;
  logic [OW-1:0]                 occ_r, occ_nxt;
  logic [5:0]                    n_r, n_nxt;
  logic [5:0]                    k_r, k_nxt;
  logic [ecrl_pkg::ENTRIES-1:0]  tag_v_r;
  logic [ecrl_pkg::ENTRIES-1:0]  st_v_r;

  logic [31:0]   tag_mem  [ecrl_pkg::ENTRIES];
  logic [5:0]    size_mem [ecrl_pkg::ENTRIES];
  logic [31:0]   task_mem [ecrl_pkg::ENTRIES];
  logic [31:0]   ctx_mem  [ecrl_pkg::ENTRIES * CW];
  logic [CW-1:0] wv_r     [ecrl_pkg::ENTRIES];

  logic [31:0] tag_q_r;
  logic [5:0]  size_q_r;
  logic [31:0] task_q_r;
  logic        tag_qv_r;
  logic        st_qv_r;
  logic [31:0] mem_q_r;

  logic           b_v_r;
  ecrl_pkg::res_t b_res_r;
  logic           b_wen_r;
  logic           out_v_r;
  ecrl_pkg::res_t out_res_r;
  logic [31:0]    out_word_r;

  logic           c_free;
  logic           b_free;
  logic           full;
  logic           empty;
  logic           b_load;
  ecrl_pkg::res_t b_res_d;
  logic           b_wen_d;
  logic           tag_we;
  logic           st_we;
  logic [5:0]     size_wd;
  logic [31:0]    task_wd;
  logic           tv_set;
  logic           tv_clr;
  logic           ent_re;
  logic [SW-1:0]  ent_ra;
  logic           ctx_we;
  logic [AW-1:0]  ctx_wa;
  logic           ctx_re;
  logic [AW-1:0]  ctx_ra;
  logic           wv_set;
  logic           wv_clr;
  logic [6:0]     widx_ext;
  logic [31:0]    tag_new;
  logic [31:0]    tag_eff;
  logic [5:0]     size_eff;
  logic [5:0]     n_min;
  logic           k_last;

  assign c_free   = !out_v_r || out_ready;
  assign b_free   = !b_v_r || c_free;
  assign full     = occ_r >= OW'(ecrl_pkg::ENTRIES);
  assign empty    = occ_r == '0;
  assign widx_ext = {2'b00, q_cmd.widx};
  assign tag_new  = id_base + 32'(wr_seq_r);
  assign ctx_wa   = AW'(wr_slot_r * CW + widx_ext);
  assign ctx_ra   = AW'(cur_r.slot * CW + k_r);
  assign tag_eff  = tag_qv_r ? tag_q_r : 32'd0;
  assign size_eff = st_qv_r ? size_q_r : 6'd0;
  assign n_min    = (cur_r.limit < size_eff) ? cur_r.limit : size_eff;
  assign k_last   = (k_r + 6'd1) == n_r;

  always_comb begin
    state_nxt   = state_r;
    cur_nxt     = cur_r;
    wr_seq_nxt  = wr_seq_r;
    wr_slot_nxt = wr_slot_r;
    rd_slot_nxt = rd_slot_r;
    occ_nxt     = occ_r;
    n_nxt       = n_r;
    k_nxt       = k_r;
    q_pop       = 1'b0;
    b_load      = 1'b0;
    b_res_d     = '0;
    b_res_d.last = 1'b1;
    b_wen_d     = 1'b0;
    tag_we      = 1'b0;
    st_we       = 1'b0;
    size_wd     = 6'd0;
    task_wd     = 32'd0;
    tv_set      = 1'b0;
    tv_clr      = 1'b0;
    ent_re      = 1'b0;
    ent_ra      = rd_slot_r;
    ctx_we      = 1'b0;
    ctx_re      = 1'b0;
    wv_set      = 1'b0;
    wv_clr      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid && b_free) begin
          q_pop = 1'b1;
          unique case (q_cmd.kind)
            ecrl_pkg::CMD_DISCARD: begin
              b_load      = 1'b1;
              occ_nxt     = '0;
              rd_slot_nxt = wr_slot_r;
            end
            ecrl_pkg::CMD_RESERVE: begin
              b_load = 1'b1;
              if (full) begin
                b_res_d.status = ecrl_pkg::ST_FULL;
              end else begin
                tag_we      = 1'b1;
                tv_set      = 1'b1;
                st_we       = 1'b1;
                wv_clr      = 1'b1;
                b_res_d.tag = tag_new;
              end
            end
            ecrl_pkg::CMD_WRITE: begin
              b_load = 1'b1;
              if (full) begin
                b_res_d.status = ecrl_pkg::ST_FULL;
              end else if (widx_ext < 7'(CW)) begin
                ctx_we = 1'b1;
                wv_set = 1'b1;
              end
            end
            ecrl_pkg::CMD_COMPLETE: begin
              b_load = 1'b1;
              if (full) begin
                b_res_d.status = ecrl_pkg::ST_FULL;
              end else begin
                st_we       = 1'b1;
                size_wd     = q_cmd.csize;
                task_wd     = q_cmd.tref;
                tv_clr      = 1'b1;
                wr_seq_nxt  = wr_seq_r + 1'b1;
                wr_slot_nxt = ecrl_pkg::next_slot(wr_slot_r);
                occ_nxt     = occ_r + 1'b1;
              end
            end
            ecrl_pkg::CMD_POP: begin
              if (empty) begin
                b_load         = 1'b1;
                b_res_d.status = ecrl_pkg::ST_NODATA;
              end else begin
                ent_re    = 1'b1;
                ent_ra    = rd_slot_r;
                cur_nxt   = q_cmd;
                state_nxt = S_LOOK;
              end
            end
            ecrl_pkg::CMD_COPY: begin
              if (!q_cmd.seq_ok) begin
                b_load         = 1'b1;
                b_res_d.status = ecrl_pkg::ST_NODATA;
              end else begin
                ent_re    = 1'b1;
                ent_ra    = q_cmd.slot;
                cur_nxt   = q_cmd;
                state_nxt = S_LOOK;
              end
            end
            default: begin
              b_load = 1'b1;
            end
          endcase
        end
      end
      S_LOOK: begin
        if (b_free) begin
          state_nxt = S_IDLE;
          if (cur_r.kind == ecrl_pkg::CMD_POP) begin
            b_load           = 1'b1;
            b_res_d.tag      = tag_eff;
            b_res_d.task_out = st_qv_r ? task_q_r : 32'd0;
            occ_nxt          = occ_r - 1'b1;
            rd_slot_nxt      = ecrl_pkg::next_slot(rd_slot_r);
          end else if (tag_eff != cur_r.cid) begin
            b_load         = 1'b1;
            b_res_d.status = ecrl_pkg::ST_NODATA;
          end else if (n_min == 6'd0) begin
            b_load = 1'b1;
          end else begin
            n_nxt     = (n_min > 6'(ecrl_pkg::COPY_MAX)) ? 6'(ecrl_pkg::COPY_MAX) : n_min;
            k_nxt     = 6'd0;
            state_nxt = S_COPY;
          end
        end
      end
      S_COPY: begin
        if (b_free) begin
          ctx_re        = 1'b1;
          b_load        = 1'b1;
          b_wen_d       = wv_r[cur_r.slot][k_r[ecrl_pkg::CW_W-1:0]];
          b_res_d.words = n_r;
          b_res_d.last  = k_last;
          k_nxt         = k_r + 6'd1;
          if (k_last) state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    b_res_d.pending = ecrl_pkg::pend_of(occ_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      wr_seq_r  <= '0;
      wr_slot_r <= '0;
      rd_slot_r <= '0;
      occ_r     <= '0;
      n_r       <= 6'd0;
      k_r       <= 6'd0;
      tag_v_r   <= '0;
      st_v_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      wr_seq_r  <= wr_seq_nxt;
      wr_slot_r <= wr_slot_nxt;
      rd_slot_r <= rd_slot_nxt;
      occ_r     <= occ_nxt;
      n_r       <= n_nxt;
      k_r       <= k_nxt;
      if (tv_set) tag_v_r[wr_slot_r] <= 1'b1;
      if (tv_clr) tag_v_r[ecrl_pkg::next_slot(wr_slot_r)] <= 1'b0;
      if (st_we)  st_v_r[wr_slot_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[wr_slot_r] <= tag_new;
    if (st_we) begin
      size_mem[wr_slot_r] <= size_wd;
      task_mem[wr_slot_r] <= task_wd;
    end
    if (ent_re) begin
      tag_q_r  <= tag_mem[ent_ra];
      size_q_r <= size_mem[ent_ra];
      task_q_r <= task_mem[ent_ra];
      tag_qv_r <= tag_v_r[ent_ra];
      st_qv_r  <= st_v_r[ent_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (ctx_we) ctx_mem[ctx_wa] <= q_cmd.wdata;
    if (ctx_re) mem_q_r <= ctx_mem[ctx_ra];
  end

  always_ff @(posedge clk) begin
    if (wv_clr) begin
      wv_r[wr_slot_r] <= '0;
    end else if (wv_set) begin
      wv_r[wr_slot_r][widx_ext[ecrl_pkg::CW_W-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r   <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (b_load) begin
        b_v_r <= 1'b1;
      end else if (c_free) begin
        b_v_r <= 1'b0;
      end
      if (c_free) out_v_r <= b_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_res_r <= b_res_d;
      b_wen_r <= b_wen_d;
    end
    if (c_free && b_v_r) begin
      out_res_r  <= b_res_r;
      out_word_r <= b_wen_r ? mem_q_r : 32'd0;
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = out_res_r;
  assign out_word  = out_word_r;

endmodule

// File: rtl/core/exception_context_ring_log_unit.sv
// Top level of the exception context ring log: stream ports and unit wiring.
//
// Items enter a decode front end and a two-entry command queue, so the input
// takes one item per cycle while the queue has room. The back end runs one
// command at a time: discard, reserve, write word, complete and unknown ops
// produce a single result directly; pop and copy first do a registered lookup
// of the entry tables, then pop gives its result and a copy of n words streams
// one word per cycle from the context memory while the staging register is
// free (a copy whose tag misses or whose n is zero gives a single result). The
// back end takes no new command until a copy is done. Results pass a staging
// register and an output register. Slots are the low bits of the sequence
// number, so the entry count is a power of two. Context words not written since
// their entry was reserved read as zero, gated by a per-entry written mask;
// there is no clearing pass after reset.
module exception_context_ring_log_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // word_index[4:0], word_data[36:5], ctx_len[42:37], task_ref[74:43],
  // req_tag[106:75], size_limit[112:107], zero pad[119:113]
  input  logic [119:0] in_tdata,
  // op[2:0]
  input  logic [2:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // tag_out[31:0], task_out[63:32], context_word[95:64], words_copied[101:96],
  // pending_count[104:102], zero pad[111:105]
  output logic [111:0] out_tdata,
  // status[1:0]
  output logic [1:0]   out_tuser,
  output logic         out_tlast
);

  ecrl_pkg::cmd_t fe_cmd;
  ecrl_pkg::cmd_t q_cmd;
  ecrl_pkg::res_t be_res;
  logic [31:0]    id_base;
  logic           q_valid;
  logic           q_pop;
  logic [31:0]    be_word;

  ecrl_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .op           (in_tuser),
    .word_index   (in_tdata[4:0]),
    .word_data    (in_tdata[36:5]),
    .ctx_len      (in_tdata[42:37]),
    .task_ref     (in_tdata[74:43]),
    .req_tag      (in_tdata[106:75]),
    .size_limit   (in_tdata[112:107]),
    .cmd          (fe_cmd),
    .id_base      (id_base)
  );

  ecrl_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_ready (in_tready),
    .push_cmd   (fe_cmd),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_cmd    (q_cmd)
  );

  ecrl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .id_base   (id_base),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (be_res),
    .out_word  (be_word)
  );

  assign out_tdata = {7'd0, be_res.pending, be_res.words, be_word,
                      be_res.task_out, be_res.tag};
  assign out_tuser = be_res.status;
  assign out_tlast = be_res.last;

endmodule

// File: rtl/core/ecrl_checker.sv
// Port-level checker for the exception context ring log, bound to the top level.
module ecrl_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [111:0] out_tdata,
  input logic [1:0]   out_tuser,
  input logic         out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("result changed while stalled");

  a_full_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ecrl_pkg::ST_FULL |->
      out_tdata[104:102] == ecrl_pkg::PEND_FULL)
    else $error("full status without a full ring");

  a_pending_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[104:102] <= ecrl_pkg::PEND_FULL)
    else $error("pending count beyond ring size");

  a_burst_only_copy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |->
      out_tuser == ecrl_pkg::ST_OK && out_tdata[101:96] != 6'd0)
    else $error("multi-result burst outside a copy");

  a_nodata_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ecrl_pkg::ST_NODATA |->
      out_tdata[101:0] == '0 && out_tlast)
    else $error("no-data result carries payload");

endmodule

bind exception_context_ring_log_unit ecrl_checker u_ecrl_checker (.*);

// File: sim/tb_top.sv
// Self-checking testbench for the exception context ring log stream unit.
`timescale 1ns / 1ps

module tb_top;

  localparam logic [2:0]  OP_SPARE_LO = 3'd6;
  localparam logic [2:0]  OP_SPARE_HI = 3'd7;
  localparam logic [31:0] INDEX_MASK  = 32'((64'd1 << ecrl_pkg::TAG_INDEX_BITS) - 1);
  localparam int          CYCLE_LIMIT = 500000;

  typedef struct packed {
    logic [2:0]  op;
    logic [4:0]  widx;
    logic [31:0] wdata;
    logic [5:0]  csize;
    logic [31:0] tref;
    logic [31:0] cid;
    logic [5:0]  limit;
  } log_request_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] tag;
    logic [31:0] task_val;
    logic [31:0] word;
    logic [5:0]  count;
    logic        is_last;
    logic [2:0]  pend;
  } log_result_t;

  class ring_log_scoreboard;
    logic [31:0] id_base;
    logic [31:0] wr_count;
    logic [31:0] rd_count;
    logic [31:0] slot_tag [ecrl_pkg::ENTRIES];
    logic [5:0]  slot_size [ecrl_pkg::ENTRIES];
    logic [31:0] slot_task [ecrl_pkg::ENTRIES];
    logic [31:0] ctx_word [ecrl_pkg::ENTRIES][ecrl_pkg::CONTEXT_WORDS];
    bit          ctx_known [ecrl_pkg::ENTRIES][ecrl_pkg::CONTEXT_WORDS];
    logic [31:0] last_reserved_tag;
    log_result_t expected_results[$];
    int          mismatch_count;

    function new();
      id_base = ecrl_pkg::ID_BASE_RESET;
      wr_count = '0;
      rd_count = '0;
      last_reserved_tag = '0;
      mismatch_count = 0;
      for (int s = 0; s < ecrl_pkg::ENTRIES; s++) begin
        slot_tag[s] = '0;
        slot_size[s] = '0;
        slot_task[s] = '0;
        for (int k = 0; k < ecrl_pkg::CONTEXT_WORDS; k++) begin
          ctx_word[s][k] = '0;
          ctx_known[s][k] = 1'b0;
        end
      end
    endfunction

    function logic [2:0] pend_now();
      logic [31:0] diff;
      diff = wr_count - rd_count;
      return (diff > 7) ? 3'd7 : diff[2:0];
    endfunction

    function void push_result(logic [1:0] status, logic [31:0] tag, logic [31:0] task_val,
                              logic [31:0] word, logic [5:0] count, logic is_last);
      log_result_t res;
      res = '{status: status, tag: tag, task_val: task_val, word: word, count: count,
              is_last: is_last, pend: pend_now()};
      expected_results.push_back(res);
    endfunction

    function bit copy_hits(logic [31:0] cid, output int slot);
      logic [31:0] seq;
      seq = cid - id_base;
      slot = int'(seq % ecrl_pkg::ENTRIES);
      if (seq > INDEX_MASK) return 1'b0;
      return slot_tag[slot] == cid;
    endfunction

    function int copy_length(int slot, logic [5:0] limit);
      int n;
      n = (limit >= slot_size[slot]) ? int'(slot_size[slot]) : int'(limit);
      if (n > ecrl_pkg::CONTEXT_WORDS) n = ecrl_pkg::CONTEXT_WORDS;
      if (n > ecrl_pkg::MAX_RESULTS) n = ecrl_pkg::MAX_RESULTS;
      return n;
    endfunction

    // clamp a copy so that it never reaches a context word that is still undefined
    function logic [5:0] safe_limit(logic [31:0] cid, logic [5:0] limit);
      int slot;
      int n;
      if (!copy_hits(cid, slot)) return limit;
      n = copy_length(slot, limit);
      for (int k = 0; k < n; k++)
        if (!ctx_known[slot][k]) return 6'(k);
      return limit;
    endfunction

    function void note_request(log_request_t r);
      bit          full;
      int          s;
      int          n;
      logic [31:0] tag;
      full = (wr_count - rd_count) >= ecrl_pkg::ENTRIES;
      s = int'(wr_count % ecrl_pkg::ENTRIES);
      case (r.op)
        ecrl_pkg::OP_DISCARD: begin
          rd_count = wr_count;
          push_result(ecrl_pkg::ST_OK, '0, '0, '0, '0, 1'b1);
        end
        ecrl_pkg::OP_RESERVE: begin
          if (full) begin
            push_result(ecrl_pkg::ST_FULL, '0, '0, '0, '0, 1'b1);
          end else begin
            tag = id_base + (wr_count & INDEX_MASK);
            slot_tag[s] = tag;
            slot_size[s] = '0;
            slot_task[s] = '0;
            for (int k = 0; k < ecrl_pkg::CONTEXT_WORDS; k++) begin
              ctx_word[s][k] = '0;
              ctx_known[s][k] = 1'b1;
            end
            last_reserved_tag = tag;
            push_result(ecrl_pkg::ST_OK, tag, '0, '0, '0, 1'b1);
          end
        end
        ecrl_pkg::OP_WRITE: begin
          if (full) begin
            push_result(ecrl_pkg::ST_FULL, '0, '0, '0, '0, 1'b1);
          end else begin
            if (r.widx < ecrl_pkg::CONTEXT_WORDS) begin
              ctx_word[s][r.widx] = r.wdata;
              ctx_known[s][r.widx] = 1'b1;
            end
            push_result(ecrl_pkg::ST_OK, '0, '0, '0, '0, 1'b1);
          end
        end
        ecrl_pkg::OP_COMPLETE: begin
          if (full) begin
            push_result(ecrl_pkg::ST_FULL, '0, '0, '0, '0, 1'b1);
          end else begin
            slot_size[s] = (r.csize > ecrl_pkg::CONTEXT_WORDS) ?
                           6'(ecrl_pkg::CONTEXT_WORDS) : r.csize;
            slot_task[s] = r.tref;
            wr_count = wr_count + 1;
            slot_tag[int'(wr_count % ecrl_pkg::ENTRIES)] = '0;
            push_result(ecrl_pkg::ST_OK, '0, '0, '0, '0, 1'b1);
          end
        end
        ecrl_pkg::OP_POP: begin
          if (wr_count == rd_count) begin
            push_result(ecrl_pkg::ST_NODATA, '0, '0, '0, '0, 1'b1);
          end else begin
            s = int'(rd_count % ecrl_pkg::ENTRIES);
            rd_count = rd_count + 1;
            push_result(ecrl_pkg::ST_OK, slot_tag[s], slot_task[s], '0, '0, 1'b1);
          end
        end
        ecrl_pkg::OP_COPY: begin
          if (!copy_hits(r.cid, s)) begin
            push_result(ecrl_pkg::ST_NODATA, '0, '0, '0, '0, 1'b1);
          end else begin
            n = copy_length(s, r.limit);
            if (n == 0)
              push_result(ecrl_pkg::ST_OK, '0, '0, '0, '0, 1'b1);
            for (int k = 0; k < n; k++)
              push_result(ecrl_pkg::ST_OK, '0, '0, ctx_word[s][k], 6'(n), k == n - 1);
          end
        end
        default: push_result(ecrl_pkg::ST_OK, '0, '0, '0, '0, 1'b1);
      endcase
    endfunction

    function void check_result(log_result_t got);
      log_result_t want;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected transfer: status=%0d tag=%h task=%h word=%h count=%0d last=%0b pend=%0d",
                   got.status, got.tag, got.task_val, got.word, got.count, got.is_last,
                   got.pend);
        return;
      end
      want = expected_results.pop_front();
      if (got !== want) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("mismatch exp: status=%0d tag=%h task=%h word=%h count=%0d last=%0b pend=%0d",
                   want.status, want.tag, want.task_val, want.word, want.count, want.is_last,
                   want.pend);
          $display("         got: status=%0d tag=%h task=%h word=%h count=%0d last=%0b pend=%0d",
                   got.status, got.tag, got.task_val, got.word, got.count, got.is_last,
                   got.pend);
        end
      end
    endfunction
  endclass

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic [31:0]  cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [119:0] in_tdata;
  logic [2:0]   in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [111:0] out_tdata;
  logic [1:0]   out_tuser;
  logic         out_tlast;

  ring_log_scoreboard sb;
  logic [31:0] recent_tags[$];
  int          items_sent;
  int          send_burst;
  int          recv_burst;
  int          hold_off_cycles;
  int          cycle_count;

  exception_context_ring_log_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL exception_context_ring_log_unit");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result('{status: out_tuser, tag: out_tdata[31:0], task_val: out_tdata[63:32],
                        word: out_tdata[95:64], count: out_tdata[101:96],
                        is_last: out_tlast, pend: out_tdata[104:102]});
  end

  function automatic int draw_gap(ref int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      burst = $urandom_range(4, 16);
      return 0;
    end
    return $urandom_range(0, 15);
  endfunction

  function automatic log_request_t ring_op(logic [2:0] op, logic [4:0] widx,
                                           logic [31:0] wdata, logic [5:0] csize,
                                           logic [31:0] tref, logic [31:0] cid,
                                           logic [5:0] limit);
    return '{op: op, widx: widx, wdata: wdata, csize: csize, tref: tref, cid: cid,
             limit: limit};
  endfunction

  task automatic send_item(input log_request_t r);
    int gap;
    gap = draw_gap(send_burst);
    if (r.op == ecrl_pkg::OP_COPY)
      r.limit = sb.safe_limit(r.cid, r.limit);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= r.op;
    in_tdata  <= {7'd0, r.limit, r.cid, r.tref, r.csize, r.wdata, r.widx};
    do @(posedge clk); while (!in_tready);
    sb.note_request(r);
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_id_base(input logic [31:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.id_base = value;
  endtask

  task automatic record_entry();
    int nw;
    logic [4:0] idx;
    logic [5:0] csz;
    send_item(ring_op(ecrl_pkg::OP_RESERVE, 5'($urandom), 32'($urandom), 6'($urandom),
                      32'($urandom), 32'($urandom), 6'($urandom)));
    recent_tags.push_back(sb.last_reserved_tag);
    if (recent_tags.size() > 8) void'(recent_tags.pop_front());
    nw = $urandom_range(0, 3);
    for (int k = 0; k < nw; k++) begin
      idx = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 31));
      send_item(ring_op(ecrl_pkg::OP_WRITE, idx, 32'($urandom), 6'($urandom),
                        32'($urandom), 32'($urandom), 6'($urandom)));
    end
    csz = ($urandom_range(0, 7) == 0) ? 6'($urandom_range(33, 63)) : 6'($urandom_range(0, 32));
    send_item(ring_op(ecrl_pkg::OP_COMPLETE, 5'($urandom), 32'($urandom), csz,
                      32'($urandom), 32'($urandom), 6'($urandom)));
  endtask

  task automatic copy_recent();
    logic [31:0] cid;
    if (recent_tags.size() == 0 || $urandom_range(0, 7) == 0)
      cid = ($urandom_range(0, 1) == 0) ? 32'($urandom) : sb.id_base + $urandom_range(0, 7);
    else
      cid = recent_tags[$urandom_range(0, recent_tags.size() - 1)];
    send_item(ring_op(ecrl_pkg::OP_COPY, 5'($urandom), 32'($urandom), 6'($urandom),
                      32'($urandom), cid, 6'($urandom_range(0, 63))));
  endtask

  task automatic random_phase(input int n_items);
    int target;
    int pick;
    target = items_sent + n_items;
    while (items_sent < target) begin
      pick = $urandom_range(0, 19);
      if (pick < 8)
        record_entry();
      else if (pick < 12)
        copy_recent();
      else if (pick < 17)
        send_item(ring_op(ecrl_pkg::OP_POP, 5'($urandom), 32'($urandom), 6'($urandom),
                          32'($urandom), 32'($urandom), 6'($urandom)));
      else if (pick == 17)
        send_item(ring_op(ecrl_pkg::OP_DISCARD, 5'($urandom), 32'($urandom), 6'($urandom),
                          32'($urandom), 32'($urandom), 6'($urandom)));
      else
        send_item(ring_op(3'($urandom_range(0, 7)), 5'($urandom), 32'($urandom),
                          6'($urandom_range(0, 63)), 32'($urandom),
                          ($urandom_range(0, 1) == 0) ? 32'($urandom)
                                                      : sb.id_base + $urandom_range(0, 7),
                          6'($urandom_range(0, 63))));
    end
  endtask

  initial begin
    int gap;
    forever begin
      @(negedge clk);
      if (rst_n) begin
        if (hold_off_cycles > 0) begin
          out_tready <= 1'b0;
          repeat (hold_off_cycles) @(negedge clk);
          hold_off_cycles = 0;
        end else begin
          gap = draw_gap(recv_burst);
          if (gap > 0) begin
            out_tready <= 1'b0;
            repeat (gap) @(negedge clk);
          end
        end
        out_tready <= 1'b1;
        do @(posedge clk); while (!out_tvalid);
      end
    end
  end

  initial begin
    logic [31:0] bases [4];
    sb = new();
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_tvalid       = 1'b0;
    in_tdata        = '0;
    in_tuser        = '0;
    out_tready      = 1'b0;
    items_sent      = 0;
    send_burst      = 0;
    recv_burst      = 0;
    hold_off_cycles = 0;
    cycle_count     = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_item(ring_op(ecrl_pkg::OP_POP, '0, '0, '0, '0, '0, '0));
    send_item(ring_op(ecrl_pkg::OP_COPY, '0, '0, '0, '0, 32'($urandom), 6'd63));
    send_item(ring_op(OP_SPARE_LO, '1, '1, '1, '1, '1, '1));
    send_item(ring_op(OP_SPARE_HI, '0, '0, '0, '0, '0, '0));
    send_item(ring_op(ecrl_pkg::OP_RESERVE, '0, '0, '0, '0, '0, '0));
    send_item(ring_op(ecrl_pkg::OP_WRITE, 5'd0, 32'hFFFF_FFFF, '0, '0, '0, '0));
    send_item(ring_op(ecrl_pkg::OP_WRITE, 5'd31, 32'h0, '0, '0, '0, '0));
    send_item(ring_op(ecrl_pkg::OP_COMPLETE, '0, '0, 6'd63, 32'hFFFF_FFFF, '0, '0));
    send_item(ring_op(ecrl_pkg::OP_COPY, '0, '0, '0, '0, ecrl_pkg::ID_BASE_RESET, 6'd63));
    send_item(ring_op(ecrl_pkg::OP_COPY, '0, '0, '0, '0, ecrl_pkg::ID_BASE_RESET, 6'd0));
    send_item(ring_op(ecrl_pkg::OP_COPY, '0, '0, '0, '0, ecrl_pkg::ID_BASE_RESET + 1,
                      6'd5));
    send_item(ring_op(ecrl_pkg::OP_COMPLETE, '0, '0, 6'd5, 32'h0000_1234, '0, '0));
    send_item(ring_op(ecrl_pkg::OP_RESERVE, '0, '0, '0, '0, '0, '0));
    send_item(ring_op(ecrl_pkg::OP_COMPLETE, '0, '0, 6'd0, 32'h0, '0, '0));
    send_item(ring_op(ecrl_pkg::OP_RESERVE, '0, '0, '0, '0, '0, '0));
    send_item(ring_op(ecrl_pkg::OP_COMPLETE, '0, '0, 6'd32, 32'($urandom), '0, '0));
    send_item(ring_op(ecrl_pkg::OP_RESERVE, '0, '0, '0, '0, '0, '0));
    send_item(ring_op(ecrl_pkg::OP_WRITE, 5'd1, 32'($urandom), '0, '0, '0, '0));
    send_item(ring_op(ecrl_pkg::OP_COMPLETE, '0, '0, 6'd1, 32'($urandom), '0, '0));
    send_item(ring_op(ecrl_pkg::OP_POP, '0, '0, '0, '0, '0, '0));
    send_item(ring_op(ecrl_pkg::OP_DISCARD, '0, '0, '0, '0, '0, '0));
    send_item(ring_op(ecrl_pkg::OP_POP, '0, '0, '0, '0, '0, '0));
    send_item(ring_op(ecrl_pkg::OP_COPY, '0, '0, '0, '0,
                      ecrl_pkg::ID_BASE_RESET + INDEX_MASK + 1, 6'd10));

    bases = '{32'h0000_0001, 32'hFFFF_FFFF, 32'($urandom), 32'hFFFF_0000};
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      write_id_base(bases[p]);
      if (p == 1) begin
        hold_off_cycles = 300;
        send_burst = 20;
      end
      random_phase(20);
    end

    wait_idle();
    repeat (12) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.expected_results.size() == 0)
      $display("PASS exception_context_ring_log_unit");
    else
      $display("FAIL exception_context_ring_log_unit");
    $finish;
  end

endmodule
